@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// clocked property that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/kbi_pkg.sv @@
// ----------------------------------------------------------------------------
// kbi_pkg
// Shared constants, codes and controller/datapath types of the keyframe
// bracket interpolator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kbi_pkg;

    localparam int MAX_TIMES = 64;
    localparam int IDX_W     = $clog2(MAX_TIMES);
    localparam int TIME_W    = 32;
    localparam int SAMPLE_W  = 32;
    localparam int BLEND_W   = 32;
    localparam int RATIO_W   = 16;
    localparam int CNT_W     = 7;
    localparam int KIND_W    = 2;
    localparam int STAT_W    = 3;
    localparam int SLOT_W    = 6;
    localparam int DIV_W     = TIME_W + 1;
    localparam int PROD_W    = SAMPLE_W + RATIO_W + 2;
    localparam int DIV_STEPS = RATIO_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(2);

    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BLEND = 2'd2;

    localparam logic [STAT_W-1:0] ST_BELOW   = 3'd0;
    localparam logic [STAT_W-1:0] ST_ABOVE   = 3'd1;
    localparam logic [STAT_W-1:0] ST_EXACT   = 3'd2;
    localparam logic [STAT_W-1:0] ST_INTERP  = 3'd3;
    localparam logic [STAT_W-1:0] ST_LOADED  = 3'd4;
    localparam logic [STAT_W-1:0] ST_BLENDED = 3'd5;

    typedef struct packed {
        logic              capture;
        logic              ram_we;
        logic              addr_last;
        logic              first_done;
        logic              scan_start;
        logic              scan_step;
        logic              div_init;
        logic              div_step;
        logic              mul_early;
        logic              mul_late;
        logic              sum;
        logic              emit;
        logic [STAT_W-1:0] emit_status;
    } t_kbi_cmd;

    typedef struct packed {
        logic t_gt;
        logic t_eq;
    } t_kbi_stat;

endpackage

@@ hw/rtl/keyframe_bracket_interpolator.sv @@
// ----------------------------------------------------------------------------
// keyframe_bracket_interpolator
// Keyframe time table with bracket search, Q0.16 ratio and sample blending.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result appears
// for exactly one cycle with o_strobe high, and the receiver cannot stall it.
// A load writes its table entry, and a blend runs two 32x18 multiplies, a
// sum, then the rounding shift. A query ends after the first compare when it
// falls at or below the first entry, after the last-entry compare when it
// falls at or above the last valid entry, in the scan for an exact hit at
// index k, and after the divide when it lands between entries k-1 and k: the
// table RAM is read at index 0, then at the last valid entry, then one entry
// a cycle from index 1, and the restoring divider then works out the ratio.
// busy falls in the cycle the result shows, so the next item can be taken
// then. An item with kind 3 is taken and dropped without a result. The
// time_count register is written through the always-ready cfg channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module keyframe_bracket_interpolator
    import kbi_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [KIND_W-1:0]          i_kind,
    input  logic [SLOT_W-1:0]          i_slot,
    input  logic signed [TIME_W-1:0]   i_time_value,
    input  logic signed [SAMPLE_W-1:0] i_sample_early,
    input  logic signed [SAMPLE_W-1:0] i_sample_late,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CNT_W-1:0]           i_cfg_data,
    output logic                       o_strobe,
    output logic [STAT_W-1:0]          o_status,
    output logic [IDX_W-1:0]           o_index_low,
    output logic [IDX_W-1:0]           o_index_high,
    output logic [RATIO_W-1:0]         o_ratio_out,
    output logic signed [BLEND_W-1:0]  o_blended
);

    t_kbi_cmd  cmd;
    t_kbi_stat stat;

    assign o_cfg_ready = 1'b1;

    kbi_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_kind   (i_kind),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .busy     (busy),
        .o_strobe (o_strobe)
    );

    kbi_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_slot         (i_slot),
        .i_time_value   (i_time_value),
        .i_sample_early (i_sample_early),
        .i_sample_late  (i_sample_late),
        .o_status       (o_status),
        .o_index_low    (o_index_low),
        .o_index_high   (o_index_high),
        .o_ratio_out    (o_ratio_out),
        .o_blended      (o_blended)
    );

endmodule

@@ hw/rtl/kbi_ram.sv @@
// ----------------------------------------------------------------------------
// kbi_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kbi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/kbi_ctrl.sv @@
// ----------------------------------------------------------------------------
// kbi_ctrl
// Sequencer: item dispatch, table scan, divider step count and result strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kbi_ctrl
    import kbi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic [KIND_W-1:0] i_kind,
    input  t_kbi_stat         i_stat,
    output t_kbi_cmd          o_cmd,
    output logic              busy,
    output logic              o_strobe
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_QRD_FIRST,
        S_QCMP_FIRST,
        S_QCMP_LAST,
        S_SCAN,
        S_DIV,
        S_DIV_END,
        S_MUL_EARLY,
        S_MUL_LATE,
        S_SUM,
        S_BLEND_OUT
    } t_state;

    t_state            r_state, n_state;
    logic              r_strobe, n_strobe;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    t_kbi_cmd          cmd;

    always_comb begin
        n_state  = r_state;
        n_strobe = 1'b0;
        n_cnt    = r_cnt;
        cmd      = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    cmd.capture = 1'b1;
                    case (i_kind)
                        KIND_LOAD:  n_state = S_LOAD;
                        KIND_QUERY: n_state = S_QRD_FIRST;
                        KIND_BLEND: n_state = S_MUL_EARLY;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_LOAD: begin
                cmd.ram_we      = 1'b1;
                cmd.emit        = 1'b1;
                cmd.emit_status = ST_LOADED;
                n_strobe        = 1'b1;
                n_state         = S_IDLE;
            end
            S_QRD_FIRST: begin
                cmd.addr_last = 1'b1;
                n_state       = S_QCMP_FIRST;
            end
            S_QCMP_FIRST: begin
                // read data holds the first entry
                if (!i_stat.t_gt) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_BELOW;
                    n_strobe        = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    cmd.first_done = 1'b1;
                    n_state        = S_QCMP_LAST;
                end
            end
            S_QCMP_LAST: begin
                // read data holds the last valid entry
                if (i_stat.t_gt || i_stat.t_eq) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_ABOVE;
                    n_strobe        = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    cmd.scan_start = 1'b1;
                    n_state        = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.t_gt) begin
                    cmd.scan_step = 1'b1;
                end else if (i_stat.t_eq) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_EXACT;
                    n_strobe        = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    cmd.div_init = 1'b1;
                    n_cnt        = '0;
                    n_state      = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (r_cnt == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = S_DIV_END;
                end else begin
                    n_cnt = r_cnt + STEP_W'(1);
                end
            end
            S_DIV_END: begin
                cmd.emit        = 1'b1;
                cmd.emit_status = ST_INTERP;
                n_strobe        = 1'b1;
                n_state         = S_IDLE;
            end
            S_MUL_EARLY: begin
                cmd.mul_early = 1'b1;
                n_state       = S_MUL_LATE;
            end
            S_MUL_LATE: begin
                cmd.mul_late = 1'b1;
                n_state      = S_SUM;
            end
            S_SUM: begin
                cmd.sum = 1'b1;
                n_state = S_BLEND_OUT;
            end
            S_BLEND_OUT: begin
                cmd.emit        = 1'b1;
                cmd.emit_status = ST_BLENDED;
                n_strobe        = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_cnt    <= n_cnt;
        end
    end

    assign o_cmd    = cmd;
    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;

endmodule

@@ hw/rtl/kbi_datapath.sv @@
// ----------------------------------------------------------------------------
// kbi_datapath
// Keyframe time table, compare, restoring divider, blend multipliers and
// result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kbi_datapath
    import kbi_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_kbi_cmd                   i_cmd,
    output t_kbi_stat                  o_stat,
    input  logic                       i_cfg_we,
    input  logic [CNT_W-1:0]           i_cfg_data,
    input  logic [SLOT_W-1:0]          i_slot,
    input  logic signed [TIME_W-1:0]   i_time_value,
    input  logic signed [SAMPLE_W-1:0] i_sample_early,
    input  logic signed [SAMPLE_W-1:0] i_sample_late,
    output logic [STAT_W-1:0]          o_status,
    output logic [IDX_W-1:0]           o_index_low,
    output logic [IDX_W-1:0]           o_index_high,
    output logic [RATIO_W-1:0]         o_ratio_out,
    output logic signed [BLEND_W-1:0]  o_blended
);

    logic [CNT_W-1:0]           r_time_count;
    logic [RATIO_W-1:0]         r_held;

    logic [SLOT_W-1:0]          r_slot;
    logic signed [TIME_W-1:0]   r_time;
    logic signed [SAMPLE_W-1:0] r_early;
    logic signed [SAMPLE_W-1:0] r_late;
    logic [IDX_W-1:0]           r_last;
    logic [IDX_W-1:0]           r_addr;
    logic [IDX_W-1:0]           r_idx;
    logic signed [TIME_W-1:0]   r_lo;
    logic [DIV_W:0]             r_rem;
    logic [DIV_W-1:0]           r_den;
    logic [RATIO_W-1:0]         r_quot;
    logic signed [PROD_W-1:0]   r_pa;
    logic signed [PROD_W-1:0]   r_pb;
    logic signed [PROD_W-1:0]   r_sum;

    logic [STAT_W-1:0]          r_out_status;
    logic [IDX_W-1:0]           r_out_lo;
    logic [IDX_W-1:0]           r_out_hi;
    logic [RATIO_W-1:0]         r_out_ratio;
    logic signed [BLEND_W-1:0]  r_out_blend;

    logic signed [TIME_W-1:0]   w_rdata;
    logic [IDX_W-1:0]           w_last;
    logic [DIV_W-1:0]           w_diff;
    logic [DIV_W-1:0]           w_span;
    logic [DIV_W:0]             w_shift;
    logic [DIV_W:0]             w_trial;
    logic [RATIO_W:0]           w_wt_early;
    logic signed [PROD_W-1:0]   w_round;
    logic signed [PROD_W-1:0]   w_scaled;

    kbi_ram #(
        .WIDTH (TIME_W),
        .DEPTH (MAX_TIMES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_we),
        .i_waddr (r_slot[IDX_W-1:0]),
        .i_wdata (r_time),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    // count clamped to the table, as the last valid index
    always_comb begin
        if (r_time_count < CNT_W'(2)) begin
            w_last = IDX_W'(1);
        end else if (r_time_count > CNT_W'(MAX_TIMES)) begin
            w_last = IDX_W'(MAX_TIMES - 1);
        end else begin
            w_last = IDX_W'(r_time_count - CNT_W'(1));
        end
    end

    assign o_stat.t_gt = (r_time > w_rdata);
    assign o_stat.t_eq = (r_time == w_rdata);

    assign w_diff  = DIV_W'({r_time[TIME_W-1], r_time} - {r_lo[TIME_W-1], r_lo});
    assign w_span  = DIV_W'({w_rdata[TIME_W-1], w_rdata} - {r_lo[TIME_W-1], r_lo});
    assign w_shift = {r_rem[DIV_W-1:0], 1'b0};
    assign w_trial = w_shift - {1'b0, r_den};

    assign w_wt_early = {1'b1, {RATIO_W{1'b0}}} - {1'b0, r_held};

    // truncate toward zero on the divide by one in Q1.16
    assign w_round  = r_sum + (r_sum[PROD_W-1] ? PROD_W'({RATIO_W{1'b1}}) : '0);
    assign w_scaled = w_round >>> RATIO_W;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_count <= COUNT_RESET;
            r_held       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_time_count <= i_cfg_data;
            end
            if (i_cmd.emit && (i_cmd.emit_status == ST_INTERP)) begin
                r_held <= r_quot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_slot  <= i_slot;
            r_time  <= i_time_value;
            r_early <= i_sample_early;
            r_late  <= i_sample_late;
            r_last  <= w_last;
            r_addr  <= '0;
        end
        if (i_cmd.addr_last) begin
            r_addr <= r_last;
        end
        if (i_cmd.first_done) begin
            r_lo   <= w_rdata;
            r_addr <= IDX_W'(1);
        end
        if (i_cmd.scan_start) begin
            r_idx  <= IDX_W'(1);
            r_addr <= IDX_W'(2);
        end
        if (i_cmd.scan_step) begin
            r_lo   <= w_rdata;
            r_idx  <= r_idx + IDX_W'(1);
            r_addr <= r_addr + IDX_W'(1);
        end
        if (i_cmd.div_init) begin
            r_rem  <= {1'b0, w_diff};
            r_den  <= w_span;
            r_quot <= '0;
        end
        if (i_cmd.div_step) begin
            if (!w_trial[DIV_W]) begin
                r_rem  <= w_trial;
                r_quot <= {r_quot[RATIO_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_shift;
                r_quot <= {r_quot[RATIO_W-2:0], 1'b0};
            end
        end
        if (i_cmd.mul_early) begin
            r_pa <= PROD_W'(r_early * $signed({1'b0, w_wt_early}));
        end
        if (i_cmd.mul_late) begin
            r_pb <= PROD_W'(r_late * $signed({2'b00, r_held}));
        end
        if (i_cmd.sum) begin
            r_sum <= r_pa + r_pb;
        end
        if (i_cmd.emit) begin
            r_out_status <= i_cmd.emit_status;
            r_out_ratio  <= '0;
            r_out_blend  <= '0;
            case (i_cmd.emit_status)
                ST_BELOW: begin
                    r_out_lo <= '0;
                    r_out_hi <= '0;
                end
                ST_ABOVE: begin
                    r_out_lo <= r_last;
                    r_out_hi <= r_last;
                end
                ST_EXACT: begin
                    r_out_lo <= r_idx;
                    r_out_hi <= r_idx;
                end
                ST_INTERP: begin
                    r_out_lo    <= r_idx - IDX_W'(1);
                    r_out_hi    <= r_idx;
                    r_out_ratio <= r_quot;
                end
                ST_LOADED: begin
                    r_out_lo <= r_slot[IDX_W-1:0];
                    r_out_hi <= r_slot[IDX_W-1:0];
                end
                ST_BLENDED: begin
                    r_out_lo    <= '0;
                    r_out_hi    <= '0;
                    r_out_blend <= w_scaled[BLEND_W-1:0];
                end
                default: begin
                    r_out_lo <= '0;
                    r_out_hi <= '0;
                end
            endcase
        end
    end

    assign o_status     = r_out_status;
    assign o_index_low  = r_out_lo;
    assign o_index_high = r_out_hi;
    assign o_ratio_out  = r_out_ratio;
    assign o_blended    = r_out_blend;

endmodule

@@ hw/rtl/kbi_checker.sv @@
// ----------------------------------------------------------------------------
// kbi_checker
// Port-level checks of the keyframe bracket interpolator, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kbi_checker
    import kbi_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic [KIND_W-1:0]  i_kind,
    input logic               o_strobe,
    input logic [STAT_W-1:0]  o_status,
    input logic [IDX_W-1:0]   o_index_low,
    input logic [IDX_W-1:0]   o_index_high,
    input logic [RATIO_W-1:0] o_ratio_out
);

    logic w_take;
    logic w_interp;
    logic w_plain;

    assign w_take   = start && !busy &&
                      (i_kind == KIND_LOAD || i_kind == KIND_QUERY || i_kind == KIND_BLEND);
    assign w_interp = o_strobe && (o_status == ST_INTERP);
    assign w_plain  = o_strobe && (o_status != ST_INTERP);

    // a real item keeps the block busy until its result is out
    `ASSERT_CLK(a_busy_after_accept, i_clk, i_rst_n, w_take |=> busy, "item taken, not busy")

    // no item ends in the state that takes it, so strobes never touch
    `ASSERT_CLK(a_strobe_single, i_clk, i_rst_n, o_strobe |=> !o_strobe, "strobe held two cycles")

    `ASSERT_CLK(a_bracket_pair, i_clk, i_rst_n, w_interp |-> (o_index_high == o_index_low + IDX_W'(1)), "bracket not adjacent")

    `ASSERT_CLK(a_plain_result, i_clk, i_rst_n, w_plain |-> (o_ratio_out == '0) && (o_index_low == o_index_high), "ratio or bracket set")

    `ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !busy && !o_strobe, "not idle after reset")

endmodule

bind keyframe_bracket_interpolator kbi_checker u_kbi_checker (.*);
